@@ design/stlbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlbc_pkg
// Shared types and constants of the static tree lookup with block counting.
// ----------------------------------------------------------------------------
package stlbc_pkg;

  // default sizing of the top level
  localparam int NODE_CAPACITY_DEF = 1024;
  localparam int MAX_DEPTH_DEF     = 16;
  localparam int NODE_BYTES_DEF    = 12;

  // fixed field widths
  localparam int KEY_W     = 32;
  localparam int BSIZE_W   = 13;
  localparam int BLOCKS_W  = 5;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RESET = BSIZE_W'(64);
  localparam logic [BLOCKS_W-1:0] BLOCKS_MAX       = BLOCKS_W'(31);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = CFG_IDX_W'(1);

  // opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_WRITTEN = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_DEPTH   = STATUS_W'(2);

  // walk sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_CHECK,
    ST_NOTE
  } walk_state_t;

endpackage

@@ design/stlbc_node_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlbc_node_mem
// Node table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stlbc_node_mem #(
  parameter int DEPTH  = stlbc_pkg::NODE_CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 54
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/stlbc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlbc_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module stlbc_div #(
  parameter int DIVIDEND_W = 14,
  parameter int DIVISOR_W  = stlbc_pkg::BSIZE_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});

    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;

    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIVIDEND_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/static_tree_lookup_block_count.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_tree_lookup_block_count
// Search-tree lookup over a loaded node table, counting distinct memory
// blocks touched along the walk.
// ----------------------------------------------------------------------------
// usage
//   input channel: an item transfers on a rising edge with start high and
//   busy low; in_opcode selects node write or lookup
//   result channel: out_valid is high for exactly one cycle per item with
//   out_found, out_blocks_touched and out_status; the receiver cannot stall
//   config channel: cfg_ready is always high, cfg_index 0 is node_count,
//   1 is block_size; other indexes are dropped; write only while idle
//   short items: a node write or a lookup on an empty tree gives its result
//   in the cycle after the transfer and busy never rises
//   for each node read, a lookup reads the node, divides its byte offset by
//   the block size in the bit-serial block divider, matches the block against
//   those seen, then notes it and picks a child; a walk that runs into the
//   depth limit ends with the depth status
//   one item at a time: busy stays high for the whole walk and is low again
//   in the cycle the result is out
//   reset: node_count 0, block_size 64, sequencer idle; the node table
//   holds garbage until written
// ----------------------------------------------------------------------------
module static_tree_lookup_block_count #(
  parameter int NODE_CAPACITY = stlbc_pkg::NODE_CAPACITY_DEF,
  parameter int MAX_DEPTH     = stlbc_pkg::MAX_DEPTH_DEF,
  parameter int NODE_BYTES    = stlbc_pkg::NODE_BYTES_DEF,
  // derived widths
  parameter int IDX_W         = $clog2(NODE_CAPACITY),
  parameter int CHILD_W       = $clog2(NODE_CAPACITY + 1),
  parameter int CFG_DATA_W    = (CHILD_W > stlbc_pkg::BSIZE_W) ? CHILD_W
                                                               : stlbc_pkg::BSIZE_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [IDX_W-1:0]                    in_node_index,
  input  logic signed [stlbc_pkg::KEY_W-1:0]  in_node_key,
  input  logic [CHILD_W-1:0]                  in_left_child,
  input  logic [CHILD_W-1:0]                  in_right_child,
  input  logic signed [stlbc_pkg::KEY_W-1:0]  in_query_key,
  // result channel
  output logic                                out_valid,
  output logic                                out_found,
  output logic [stlbc_pkg::BLOCKS_W-1:0]      out_blocks_touched,
  output logic [stlbc_pkg::STATUS_W-1:0]      out_status,
  // config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stlbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data
);

  localparam int KEY_W     = stlbc_pkg::KEY_W;
  localparam int BSIZE_W   = stlbc_pkg::BSIZE_W;
  localparam int BLOCKS_W  = stlbc_pkg::BLOCKS_W;
  localparam int STATUS_W  = stlbc_pkg::STATUS_W;
  localparam int NODE_W    = KEY_W + 2 * CHILD_W;
  // byte offset of a node, and the block number after the divide
  localparam int PROD_W    = IDX_W + $clog2(NODE_BYTES + 1);
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int VIS_IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_EXT_W = (CNT_W > BLOCKS_W) ? CNT_W : BLOCKS_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CHILD_W-1:0] node_count_r;
  logic [BSIZE_W-1:0] block_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      block_size_r <= stlbc_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stlbc_pkg::REG_NODE_COUNT: node_count_r <= cfg_data[CHILD_W-1:0];
        stlbc_pkg::REG_BLOCK_SIZE: block_size_r <= cfg_data[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // walk state
  // ---------------------------------------------------------------------------
  stlbc_pkg::walk_state_t state_r, state_nxt;

  logic [CHILD_W-1:0]          limit_r, limit_nxt;     // effective node count
  logic [BSIZE_W-1:0]          bsize_r, bsize_nxt;     // divisor, zero forced to one
  logic signed [KEY_W-1:0]     q_r, q_nxt;             // key being searched
  logic [IDX_W-1:0]            cur_r, cur_nxt;         // node under visit
  logic [CNT_W-1:0]            steps_r, steps_nxt;     // nodes read so far
  logic [CNT_W-1:0]            count_r, count_nxt;     // distinct blocks so far
  logic [MAX_DEPTH-1:0]        hit_r, hit_nxt;         // block already seen, per entry
  logic [PROD_W-1:0]           visited_r [MAX_DEPTH];  // blocks seen on this walk

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [BLOCKS_W-1:0]         out_blocks_r, out_blocks_nxt;
  logic [STATUS_W-1:0]         out_status_r, out_status_nxt;

  // memory and divider hookup
  logic                        mem_wr_en;
  logic                        mem_rd_en;
  logic [NODE_W-1:0]           mem_rd_data;
  logic signed [KEY_W-1:0]     node_key;
  logic [CHILD_W-1:0]          node_left;
  logic [CHILD_W-1:0]          node_right;
  logic                        div_start;
  logic                        div_done;
  logic [PROD_W-1:0]           div_quo;
  logic [PROD_W-1:0]           node_offset;

  logic                        vis_we;
  logic [CHILD_W-1:0]          lim_now;
  logic [CHILD_W-1:0]          next_child;
  logic [CNT_W-1:0]            count_inc;

  function automatic logic [BLOCKS_W-1:0] sat_blocks(input logic [CNT_W-1:0] c);
    logic [CNT_EXT_W-1:0] ext;
    ext = CNT_EXT_W'(c);
    if (ext > CNT_EXT_W'(stlbc_pkg::BLOCKS_MAX)) begin
      return stlbc_pkg::BLOCKS_MAX;
    end
    return ext[BLOCKS_W-1:0];
  endfunction

  assign node_key    = mem_rd_data[NODE_W-1 -: KEY_W];
  assign node_left   = mem_rd_data[2*CHILD_W-1 -: CHILD_W];
  assign node_right  = mem_rd_data[CHILD_W-1:0];
  assign node_offset = PROD_W'(cur_r) * PROD_W'(NODE_BYTES);
  assign lim_now     = (node_count_r > CHILD_W'(NODE_CAPACITY)) ? CHILD_W'(NODE_CAPACITY)
                                                                : node_count_r;
  assign next_child  = (q_r < node_key) ? node_left : node_right;

  // ---------------------------------------------------------------------------
  // sequencer: read node, divide offset by block size, look up the block
  // among those seen, then note a new block, compare keys and pick the child
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    bsize_nxt      = bsize_r;
    q_nxt          = q_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    count_nxt      = count_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = out_found_r;
    out_blocks_nxt = out_blocks_r;
    out_status_nxt = out_status_r;
    mem_wr_en      = 1'b0;
    mem_rd_en      = 1'b0;
    div_start      = 1'b0;
    vis_we         = 1'b0;
    count_inc      = count_r + CNT_W'(1);

    unique case (state_r)
      stlbc_pkg::ST_IDLE: begin
        if (start) begin
          if (in_opcode == stlbc_pkg::OP_WRITE) begin
            // slots beyond capacity are dropped, the result still goes out
            mem_wr_en      = ({1'b0, in_node_index} < CHILD_W'(NODE_CAPACITY));
            out_valid_nxt  = 1'b1;
            out_found_nxt  = 1'b0;
            out_blocks_nxt = '0;
            out_status_nxt = stlbc_pkg::STATUS_WRITTEN;
          end else begin
            limit_nxt = lim_now;
            bsize_nxt = (block_size_r == '0) ? BSIZE_W'(1) : block_size_r;
            q_nxt     = in_query_key;
            cur_nxt   = '0;
            steps_nxt = '0;
            count_nxt = '0;
            if (lim_now == '0) begin
              // empty tree
              out_valid_nxt  = 1'b1;
              out_found_nxt  = 1'b0;
              out_blocks_nxt = '0;
              out_status_nxt = stlbc_pkg::STATUS_DONE;
            end else begin
              state_nxt = stlbc_pkg::ST_READ;
            end
          end
        end
      end

      stlbc_pkg::ST_READ: begin
        if (steps_r == CNT_W'(MAX_DEPTH)) begin
          // walk would go past the depth limit
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b0;
          out_blocks_nxt = sat_blocks(count_r);
          out_status_nxt = stlbc_pkg::STATUS_DEPTH;
          state_nxt      = stlbc_pkg::ST_IDLE;
        end else begin
          mem_rd_en = 1'b1;
          div_start = 1'b1;
          steps_nxt = steps_r + CNT_W'(1);
          state_nxt = stlbc_pkg::ST_DIV;
        end
      end

      stlbc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = stlbc_pkg::ST_CHECK;
        end
      end

      stlbc_pkg::ST_CHECK: begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
          hit_nxt[i] = (CNT_W'(i) < count_r) && (visited_r[i] == div_quo);
        end
        state_nxt = stlbc_pkg::ST_NOTE;
      end

      stlbc_pkg::ST_NOTE: begin
        if (!(|hit_r)) begin
          vis_we    = 1'b1;
          count_nxt = count_inc;
        end
        if (q_r == node_key) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b1;
          out_blocks_nxt = sat_blocks(count_nxt);
          out_status_nxt = stlbc_pkg::STATUS_DONE;
          state_nxt      = stlbc_pkg::ST_IDLE;
        end else if (next_child < limit_r) begin
          cur_nxt   = next_child[IDX_W-1:0];
          state_nxt = stlbc_pkg::ST_READ;
        end else begin
          // null or out-of-range child ends the walk
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b0;
          out_blocks_nxt = sat_blocks(count_nxt);
          out_status_nxt = stlbc_pkg::STATUS_DONE;
          state_nxt      = stlbc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = stlbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stlbc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
      count_r     <= '0;
      cur_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    limit_r      <= limit_nxt;
    bsize_r      <= bsize_nxt;
    q_r          <= q_nxt;
    hit_r        <= hit_nxt;
    out_found_r  <= out_found_nxt;
    out_blocks_r <= out_blocks_nxt;
    out_status_r <= out_status_nxt;
  end

  // visited block list, only entries below count_r are meaningful
  always_ff @(posedge clk) begin
    if (vis_we) begin
      visited_r[count_r[VIS_IDX_W-1:0]] <= div_quo;
    end
  end

  // ---------------------------------------------------------------------------
  // node table and block divider
  // ---------------------------------------------------------------------------
  stlbc_node_mem #(
    .DEPTH  (NODE_CAPACITY),
    .ADDR_W (IDX_W),
    .DATA_W (NODE_W)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (in_node_index),
    .wr_data ({in_node_key, in_left_child, in_right_child}),
    .rd_en   (mem_rd_en),
    .rd_addr (cur_r),
    .rd_data (mem_rd_data)
  );

  stlbc_div #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR_W  (BSIZE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (node_offset),
    .divisor  (bsize_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // outputs
  // ---------------------------------------------------------------------------
  assign busy               = (state_r != stlbc_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_blocks_touched = out_blocks_r;
  assign out_status         = out_status_r;

endmodule
